// ----- src/lsfl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Linked stack package
// Shared codes, state type and memory control bundle for the linked stack.
// ----------------------------------------------------------------------------
package lsfl_pkg;

    localparam logic [1:0] FUNC_PUSH = 2'd0;
    localparam logic [1:0] FUNC_POP  = 2'd1;
    localparam logic [1:0] FUNC_PEEK = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam int VALUE_W = 32;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic val_rd;
        logic link_rd;
        logic val_wr;
        logic link_wr;
    } mem_ctl_t;

endpackage
`default_nettype wire

// ----- src/linked_stack_with_free_list_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Linked stack with free list
// Stack of 32-bit values kept as a linked list in a pool of SLOTS slots.
// ----------------------------------------------------------------------------
// In the cycle of acceptance the value and link memories are read at the
// top slot or the free-list head; in the execute state, once the output
// register can take the result, the link read is resolved, the lists are
// relinked and the memories are written back. A new word is taken while the
// previous result still waits on the output register. There is no clearing
// pass after reset: a high-water count of used slots supplies the initial
// free-list links. Push answers full once SLOTS values are held; pop and
// peek on an empty stack answer empty with a zero value.
module linked_stack_with_free_list_top #(
    parameter int SLOTS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [1:0] func, [33:2] push_value, rest zero
    input  wire logic [39:0]          s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [1:0] status, [33:2] top_value, then depth_now, rest zero
    output logic [((34 + $clog2(SLOTS + 1) + 7) / 8) * 8 - 1:0] m_tdata
);
    import lsfl_pkg::*;

    localparam int SW  = $clog2(SLOTS + 1);
    localparam int AW  = $clog2(SLOTS);
    localparam int ODW = ((34 + SW + 7) / 8) * 8;

    mem_ctl_t          mem_ctl;
    logic [AW-1:0]     val_rd_addr, link_rd_addr, val_wr_addr, link_wr_addr;
    logic [31:0]       val_wr_data, val_rd_data;
    logic [SW-1:0]     link_wr_data, link_rd_data;
    logic [1:0]        out_status;
    logic [31:0]       out_top;
    logic [SW-1:0]     out_depth;

    lsfl_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_value_ram (
        .aclk    (aclk),
        .rd_en   (mem_ctl.val_rd),
        .rd_addr (val_rd_addr),
        .rd_data (val_rd_data),
        .wr_en   (mem_ctl.val_wr),
        .wr_addr (val_wr_addr),
        .wr_data (val_wr_data)
    );

    lsfl_ram #(
        .WIDTH (SW),
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_link_ram (
        .aclk    (aclk),
        .rd_en   (mem_ctl.link_rd),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd_data),
        .wr_en   (mem_ctl.link_wr),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data)
    );

    lsfl_ctrl #(
        .SLOTS (SLOTS),
        .SW    (SW),
        .AW    (AW)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_func      (s_tdata[1:0]),
        .in_value     (s_tdata[33:2]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_status   (out_status),
        .out_top      (out_top),
        .out_depth    (out_depth),
        .mem_ctl      (mem_ctl),
        .val_rd_addr  (val_rd_addr),
        .link_rd_addr (link_rd_addr),
        .val_wr_addr  (val_wr_addr),
        .link_wr_addr (link_wr_addr),
        .val_wr_data  (val_wr_data),
        .link_wr_data (link_wr_data),
        .val_rd_data  (val_rd_data),
        .link_rd_data (link_rd_data)
    );

    assign m_tdata = ODW'({out_depth, out_top, out_status});

    // A refused push means the pool is exhausted.
    a_full_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_status == STATUS_FULL) |-> (out_depth == SW'(SLOTS)))
        else $error("full status with a pool that is not exhausted");

    // An empty answer comes only from an empty stack.
    a_empty_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_status == STATUS_EMPTY) |-> (out_depth == '0))
        else $error("empty status with elements held");

    // Each word is worked on alone until its write-back.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("word accepted during write-back");

    // The link memory is never read and written in the same cycle.
    a_link_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_ctl.link_rd && mem_ctl.link_wr))
        else $error("link memory read and write overlap");

endmodule
`default_nettype wire

// ----- src/lsfl_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Linked stack slot memory
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lsfl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic             aclk,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // The read data holds until the next read, so a stalled consumer sees it.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- src/lsfl_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Linked stack controller
// Issues slot reads on accept, then updates the lists and writes back.
// ----------------------------------------------------------------------------
module lsfl_ctrl #(
    parameter int SLOTS = 16,
    parameter int SW    = 5,
    parameter int AW    = 4
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [1:0]             in_func,
    input  wire logic [31:0]            in_value,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic      [1:0]             out_status,
    output logic      [31:0]            out_top,
    output logic      [SW-1:0]          out_depth,
    output lsfl_pkg::mem_ctl_t          mem_ctl,
    output logic      [AW-1:0]          val_rd_addr,
    output logic      [AW-1:0]          link_rd_addr,
    output logic      [AW-1:0]          val_wr_addr,
    output logic      [AW-1:0]          link_wr_addr,
    output logic      [31:0]            val_wr_data,
    output logic      [SW-1:0]          link_wr_data,
    input  wire logic [31:0]            val_rd_data,
    input  wire logic [SW-1:0]          link_rd_data
);
    import lsfl_pkg::*;

    localparam logic [SW-1:0] NULL_SLOT = SW'(SLOTS);

    state_t          state_reg, state_next;
    logic [1:0]      func_reg;
    logic [31:0]     value_reg;
    logic [SW-1:0]   top_reg, top_next;
    logic [SW-1:0]   free_reg, free_next;
    logic [SW-1:0]   count_reg, count_next;
    logic [SW-1:0]   hw_reg, hw_next;
    logic [SW-1:0]   addr_reg;
    logic            fresh_reg;
    logic            out_valid_reg, out_valid_next;
    logic [1:0]      status_reg, status_next;
    logic [31:0]     top_val_reg, top_val_next;
    logic [SW-1:0]   depth_reg;

    logic            accept;
    logic            exec_go;
    logic [SW-1:0]   rd_slot;
    logic [SW-1:0]   link_q;
    logic            push_ok;
    logic            pop_ok;

    assign accept  = in_valid && in_ready;
    assign exec_go = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);

    // A push follows the free list, a pop follows the stack.
    assign rd_slot = (in_func == FUNC_PUSH) ? free_reg : top_reg;

    // Slots at or above the high-water mark were never written, so their link
    // is taken as simply the next slot number instead of the memory read.
    assign link_q = fresh_reg ? SW'(addr_reg + SW'(1)) : link_rd_data;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State machine outputs.
    always_comb begin
        in_ready        = 1'b0;
        mem_ctl.val_rd  = 1'b0;
        mem_ctl.link_rd = 1'b0;
        mem_ctl.val_wr  = 1'b0;
        mem_ctl.link_wr = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready        = 1'b1;
                mem_ctl.val_rd  = in_valid && (top_reg < NULL_SLOT);
                mem_ctl.link_rd = in_valid && (rd_slot < NULL_SLOT);
            end
            ST_EXEC: begin
                mem_ctl.val_wr  = exec_go && push_ok;
                mem_ctl.link_wr = exec_go && (push_ok || pop_ok);
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign val_rd_addr  = top_reg[AW-1:0];
    assign link_rd_addr = rd_slot[AW-1:0];
    assign val_wr_addr  = free_reg[AW-1:0];
    assign link_wr_addr = (func_reg == FUNC_PUSH) ? free_reg[AW-1:0] : top_reg[AW-1:0];
    assign val_wr_data  = value_reg;
    assign link_wr_data = (func_reg == FUNC_PUSH) ? top_reg : free_reg;

    // Operation result and list update.
    always_comb begin
        push_ok      = 1'b0;
        pop_ok       = 1'b0;
        top_next     = top_reg;
        free_next    = free_reg;
        count_next   = count_reg;
        hw_next      = hw_reg;
        status_next  = STATUS_OK;
        top_val_next = '0;
        case (func_reg)
            FUNC_PUSH: begin
                if (count_reg >= NULL_SLOT || free_reg >= NULL_SLOT) begin
                    status_next = STATUS_FULL;
                end else begin
                    push_ok    = 1'b1;
                    top_next   = free_reg;
                    free_next  = link_q;
                    count_next = SW'(count_reg + SW'(1));
                    if (free_reg >= hw_reg) begin
                        hw_next = SW'(hw_reg + SW'(1));
                    end
                end
            end
            FUNC_POP, FUNC_PEEK: begin
                if (top_reg >= NULL_SLOT) begin
                    status_next = STATUS_EMPTY;
                end else begin
                    top_val_next = val_rd_data;
                    if (func_reg == FUNC_POP) begin
                        pop_ok    = 1'b1;
                        top_next  = link_q;
                        free_next = top_reg;
                        if (count_reg != '0) begin
                            count_next = SW'(count_reg - SW'(1));
                        end
                    end
                end
            end
            default: begin
                status_next = STATUS_OK;
            end
        endcase
    end

    always_comb begin
        if (exec_go) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            top_reg       <= NULL_SLOT;
            free_reg      <= '0;
            count_reg     <= '0;
            hw_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (exec_go) begin
                top_reg   <= top_next;
                free_reg  <= free_next;
                count_reg <= count_next;
                hw_reg    <= hw_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg  <= in_func;
            value_reg <= in_value;
            addr_reg  <= rd_slot;
            fresh_reg <= (rd_slot >= hw_reg);
        end
        if (exec_go) begin
            status_reg  <= status_next;
            top_val_reg <= top_val_next;
            depth_reg   <= count_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = status_reg;
    assign out_top    = top_val_reg;
    assign out_depth  = depth_reg;

endmodule
`default_nettype wire
